FILE: hw/rtl/trigram_markov_letter_sampler_defines.svh
// Assertion macros for the trigram letter sampler.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TRIGRAM_MARKOV_LETTER_SAMPLER_DEFINES_SVH
`define TRIGRAM_MARKOV_LETTER_SAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
`define TMLS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TMLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TMLS_ASSERT(label, clk, rst_n, prop, msg)
`define TMLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/tmls_pkg.sv
// Shared types and codes of the trigram letter sampler.
// Used by tmls_ctrl, tmls_dp and the top level; no dependencies.
package tmls_pkg;

    localparam logic [5:0] NO_LETTER   = 6'd63;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam int         UPPER_LIMIT  = 26;
    localparam logic [7:0] RESET_MAX_LEN = 8'd16;

    typedef enum logic [1:0] {
        OP_TRAIN = 2'd0,
        OP_START = 2'd1,
        OP_STEP  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_LETTER    = 2'd0,
        ST_FINISHED  = 2'd1,
        ST_UNTRAINED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RES_UNTRAINED = 2'd0,
        RES_FINISHED  = 2'd1,
        RES_START     = 2'd2,
        RES_LETTER    = 2'd3
    } t_res;

    typedef enum logic [1:0] {
        MOD_RA  = 2'd0,
        MOD_RB  = 2'd1,
        MOD_TOT = 2'd2
    } t_mod_sel;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  text_byte;
        logic        end_of_word;
        logic [30:0] random_a;
        logic [30:0] random_b;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] letter;
        logic [7:0] second_letter;
        logic       pair_has_successor;
    } t_out;

    typedef struct packed {
        logic     clr_step;
        logic     bump_issue;
        logic     bump_sel;
        logic     bump_write;
        logic     tr_shift;
        logic     tr_finish;
        logic     mod_start;
        t_mod_sel mod_sel;
        logic     mod_step;
        logic     set_first;
        logic     set_second;
        logic     rd_start;
        logic     rd_run;
        logic     acc_sum;
        logic     walk;
        logic     emit;
        t_res     res_kind;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic trained;
        logic clr_last;
        logic mod_done;
        logic rd_last;
        logic step_end;
        logic sum_zero;
        logic pick_end;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/trigram_markov_letter_sampler.sv
// Trigram letter sampler, one item at a time; o_ready is high only while idle.
// Train: no result. Start: the result follows the reciprocal reductions of random_a and
// random_b and the pair sum. Step: sum, serial modulo, walk; the sum alone on an empty pair,
// and no memory pass when untrained or the word is over (also a start when untrained).
// Next item is taken in the cycle after the result is issued; an untaken result holds back the next result.
// Reset clears control state, then a clearing pass zeroes every count before the first item is taken.
module trigram_markov_letter_sampler #(
    parameter int ALPHABET_SIZE = 26,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tmls_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output tmls_pkg::t_out o_item,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [7:0]     i_cfg_data
);
    import tmls_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign o_ready     = in_ready;
    assign o_cfg_ready = 1'b1;

    tmls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tmls_dp #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_valid && in_ready),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

endmodule

FILE: hw/rtl/tmls_ctrl.sv
// Sequencer of the trigram letter sampler: clearing pass, train, start and step.
// Depends on tmls_pkg; drives tmls_dp through t_cmd and reads t_sts.
module tmls_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tmls_pkg::t_sts i_sts,
    output tmls_pkg::t_cmd o_cmd
);
    import tmls_pkg::*;

    typedef enum logic [14:0] {
        S_CLEAR    = 15'b000000000000001,
        S_IDLE     = 15'b000000000000010,
        S_DISPATCH = 15'b000000000000100,
        S_TR_RD1   = 15'b000000000001000,
        S_TR_WR1   = 15'b000000000010000,
        S_TR_RD2   = 15'b000000000100000,
        S_TR_WR2   = 15'b000000001000000,
        S_MOD_A    = 15'b000000010000000,
        S_MOD_B    = 15'b000000100000000,
        S_SUM      = 15'b000001000000000,
        S_SUM_END  = 15'b000010000000000,
        S_MOD_T    = 15'b000100000000000,
        S_WALK     = 15'b001000000000000,
        S_WALK_END = 15'b010000000000000,
        S_EMIT     = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    t_res   r_kind, n_kind;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_kind  <= RES_UNTRAINED;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_TRAIN: n_state = S_TR_RD1;
                    OP_START: begin
                        if (!i_sts.trained) begin
                            n_kind  = RES_UNTRAINED;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.mod_start = 1'b1;
                            o_cmd.mod_sel   = MOD_RA;
                            n_state         = S_MOD_A;
                        end
                    end
                    OP_STEP: begin
                        if (!i_sts.trained) begin
                            n_kind  = RES_UNTRAINED;
                            n_state = S_EMIT;
                        end else if (i_sts.step_end) begin
                            n_kind  = RES_FINISHED;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.rd_start = 1'b1;
                            n_state        = S_SUM;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_TR_RD1: begin
                o_cmd.bump_issue = 1'b1;
                o_cmd.bump_sel   = 1'b0;
                n_state          = S_TR_WR1;
            end
            S_TR_WR1: begin
                o_cmd.bump_write = 1'b1;
                o_cmd.tr_shift   = 1'b1;
                n_state          = S_TR_RD2;
            end
            S_TR_RD2: begin
                o_cmd.bump_issue = 1'b1;
                o_cmd.bump_sel   = 1'b1;
                n_state          = S_TR_WR2;
            end
            S_TR_WR2: begin
                o_cmd.bump_write = 1'b1;
                o_cmd.tr_finish  = 1'b1;
                n_state          = S_IDLE;
            end
            S_MOD_A: begin
                // first letter is taken in the cycle after its product is loaded
                o_cmd.set_first = 1'b1;
                o_cmd.mod_start = 1'b1;
                o_cmd.mod_sel   = MOD_RB;
                n_state         = S_MOD_B;
            end
            S_MOD_B: begin
                o_cmd.set_second = 1'b1;
                o_cmd.rd_start   = 1'b1;
                n_state          = S_SUM;
            end
            S_SUM: begin
                o_cmd.rd_run  = 1'b1;
                o_cmd.acc_sum = 1'b1;
                if (i_sts.rd_last) n_state = S_SUM_END;
            end
            S_SUM_END: begin
                if (i_sts.op == OP_START) begin
                    n_kind  = RES_START;
                    n_state = S_EMIT;
                end else if (i_sts.sum_zero) begin
                    n_kind  = RES_FINISHED;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_sel   = MOD_TOT;
                    n_state         = S_MOD_T;
                end
            end
            S_MOD_T: begin
                if (i_sts.mod_done) begin
                    o_cmd.rd_start = 1'b1;
                    n_state        = S_WALK;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_WALK: begin
                o_cmd.rd_run = 1'b1;
                o_cmd.walk   = 1'b1;
                if (i_sts.rd_last) n_state = S_WALK_END;
            end
            S_WALK_END: begin
                n_kind  = i_sts.pick_end ? RES_FINISHED : RES_LETTER;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.res_kind = r_kind;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: hw/rtl/tmls_dp.sv
// Datapath of the trigram letter sampler: count memory, reciprocal start-letter
// reduction, serial modulo unit, word state and output register. Depends on tmls_pkg
// and the defines header.
`include "trigram_markov_letter_sampler_defines.svh"
module tmls_dp #(
    parameter int ALPHABET_SIZE = 26,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  tmls_pkg::t_in  i_item,
    input  logic           i_cfg_we,
    input  logic [7:0]     i_cfg_data,
    input  tmls_pkg::t_cmd i_cmd,
    output tmls_pkg::t_sts o_sts,
    output logic           o_valid,
    input  logic           i_ready,
    output tmls_pkg::t_out o_item
);
    import tmls_pkg::*;

    localparam int SUCC   = ALPHABET_SIZE + 1;
    localparam int DEPTH  = ALPHABET_SIZE * ALPHABET_SIZE * SUCC;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int SEL_W  = $clog2(SUCC);
    localparam int K_W    = $clog2(SUCC + 1);
    localparam int SUM_W  = COUNT_WIDTH + $clog2(SUCC);
    localparam int DVD_W  = 31;
    localparam int BIT_W  = $clog2(DVD_W + 1);
    // quotient by ALPHABET_SIZE as a multiply by a rounded-up reciprocal
    localparam int MUL_SH = DVD_W + $clog2(ALPHABET_SIZE);
    localparam longint RECIP_L = ((longint'(1) <<< MUL_SH) + longint'(ALPHABET_SIZE)
                                 - longint'(1)) / longint'(ALPHABET_SIZE);
    localparam logic [31:0] RECIP = 32'(RECIP_L);

    function automatic logic [5:0] letter_index(logic [7:0] c);
        logic [7:0] idx;
        idx = 8'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) idx = c - CHAR_UPPER_A;
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) idx = c - CHAR_LOWER_A;
        else return NO_LETTER;
        return (int'(idx) < ALPHABET_SIZE) ? idx[5:0] : NO_LETTER;
    endfunction

    function automatic logic [ADDR_W-1:0] pair_addr(int c0, int c1, int s);
        int t;
        t = (c0 * ALPHABET_SIZE + c1) * SUCC + s;
        return ADDR_W'(t);
    endfunction

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_data;

    t_in              r_item;
    logic [5:0]       r_older, r_newer;
    logic [IDX_W-1:0] r_first, r_second;
    logic [7:0]       r_wlen, r_max;
    logic             r_trained;
    logic [ADDR_W-1:0] r_clr, r_waddr;
    logic             r_wpend;
    logic [K_W-1:0]   r_k;
    logic             r_vld;
    logic [SEL_W-1:0] r_idx, r_pick;
    logic             r_found;
    logic [SUM_W-1:0] r_sum, r_div, r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [62:0]      r_prod;
    logic [BIT_W-1:0] r_bitcnt;
    logic             r_out_valid;
    t_out             r_out;

    logic [5:0]        c_idx, next1;
    logic              bump_ok0, bump_ok1;
    logic [ADDR_W-1:0] raddr, waddr;
    logic              re, we, rd_issue, rd_last;
    logic [COUNT_WIDTH-1:0] wdata;
    logic [SUM_W:0]    rem_sh;
    logic [DVD_W-1:0]  dvd_sel;
    logic [IDX_W-1:0]  rem_const;

    assign c_idx    = letter_index(r_item.text_byte);
    assign next1    = (c_idx == NO_LETTER) ? 6'(ALPHABET_SIZE) : c_idx;
    assign bump_ok0 = (int'(r_older) < ALPHABET_SIZE) && (int'(r_newer) < ALPHABET_SIZE);
    assign bump_ok1 = bump_ok0 && r_item.end_of_word;
    assign rd_issue = i_cmd.rd_run && (int'(r_k) < SUCC);
    assign rd_last  = r_vld && (r_idx == SEL_W'(SUCC - 1));
    assign rem_sh   = {r_rem, r_dvd[DVD_W-1]};
    // the remainder is below ALPHABET_SIZE, so its low bits alone are exact
    assign rem_const = r_dvd[IDX_W-1:0]
                     - IDX_W'(r_prod[MUL_SH +: IDX_W] * IDX_W'(ALPHABET_SIZE));

    always_comb begin
        case (i_cmd.mod_sel)
            MOD_RB:  dvd_sel = r_item.random_b;
            default: dvd_sel = r_item.random_a;
        endcase
    end

    always_comb begin
        if (i_cmd.bump_issue) begin
            raddr = i_cmd.bump_sel
                  ? pair_addr(int'(r_older), int'(r_newer), ALPHABET_SIZE)
                  : pair_addr(int'(r_older), int'(r_newer), int'(next1));
        end else begin
            raddr = pair_addr(int'(r_first), int'(r_second), int'(r_k));
        end
        re = i_cmd.bump_issue || rd_issue;
        if (i_cmd.clr_step) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = '0;
        end else begin
            // saturate: a full count stays as it is
            we    = i_cmd.bump_write && r_wpend && (r_rd_data != '1);
            waddr = r_waddr;
            wdata = r_rd_data + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (re) r_rd_data <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_item <= i_item;
        if (i_cmd.bump_issue) r_waddr <= raddr;
        if (i_cmd.mod_start) begin
            r_dvd  <= dvd_sel;
            r_prod <= 63'(dvd_sel) * 63'(RECIP);
            r_div  <= (i_cmd.mod_sel == MOD_TOT) ? r_sum : SUM_W'(ALPHABET_SIZE);
        end else if (i_cmd.mod_step) begin
            r_dvd <= r_dvd << 1;
        end
        if (rd_issue) r_idx <= r_k[SEL_W-1:0];
        if (i_cmd.emit) begin
            r_out <= '0;
            case (i_cmd.res_kind)
                RES_UNTRAINED: r_out.status <= ST_UNTRAINED;
                RES_FINISHED:  r_out.status <= ST_FINISHED;
                RES_START: begin
                    r_out.status <= ST_LETTER;
                    r_out.letter <= (int'(r_first) < UPPER_LIMIT)
                                  ? CHAR_UPPER_A + 8'(r_first)
                                  : CHAR_LOWER_A + 8'(r_first);
                    r_out.second_letter      <= CHAR_LOWER_A + 8'(r_second);
                    r_out.pair_has_successor <= (r_sum != '0);
                end
                RES_LETTER: begin
                    r_out.status <= ST_LETTER;
                    r_out.letter <= CHAR_LOWER_A + 8'(r_pick);
                end
                default: r_out.status <= ST_FINISHED;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older     <= NO_LETTER;
            r_newer     <= NO_LETTER;
            r_first     <= '0;
            r_second    <= '0;
            r_wlen      <= '0;
            r_max       <= RESET_MAX_LEN;
            r_trained   <= 1'b0;
            r_clr       <= '0;
            r_wpend     <= 1'b0;
            r_k         <= '0;
            r_vld       <= 1'b0;
            r_pick      <= '0;
            r_found     <= 1'b0;
            r_sum       <= '0;
            r_rem       <= '0;
            r_bitcnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_max <= i_cfg_data;
            if (i_cmd.clr_step) r_clr <= r_clr + ADDR_W'(1);
            if (i_cmd.bump_issue) r_wpend <= i_cmd.bump_sel ? bump_ok1 : bump_ok0;
            if (i_cmd.tr_shift) begin
                r_older <= r_newer;
                r_newer <= c_idx;
            end
            if (i_cmd.tr_finish) begin
                r_trained <= 1'b1;
                if (r_item.end_of_word) begin
                    r_older <= NO_LETTER;
                    r_newer <= NO_LETTER;
                end
            end
            // one quotient bit per cycle, restoring
            if (i_cmd.mod_start) begin
                r_rem    <= '0;
                r_bitcnt <= '0;
            end else if (i_cmd.mod_step) begin
                r_rem    <= (rem_sh >= {1'b0, r_div}) ? SUM_W'(rem_sh - {1'b0, r_div})
                                                      : SUM_W'(rem_sh);
                r_bitcnt <= r_bitcnt + BIT_W'(1);
            end else if (i_cmd.walk && r_vld && !r_found) begin
                if (r_rem < SUM_W'(r_rd_data)) begin
                    r_found <= 1'b1;
                    r_pick  <= r_idx;
                end else begin
                    r_rem <= r_rem - SUM_W'(r_rd_data);
                end
            end
            if (i_cmd.set_first) r_first <= rem_const;
            if (i_cmd.set_second) begin
                r_second <= rem_const;
                r_wlen   <= 8'd2;
            end
            if (i_cmd.rd_start) begin
                r_k     <= '0;
                r_vld   <= 1'b0;
                r_found <= 1'b0;
                r_pick  <= SEL_W'(ALPHABET_SIZE);
            end else if (i_cmd.rd_run) begin
                r_vld <= rd_issue;
                if (rd_issue) r_k <= r_k + K_W'(1);
            end
            if (i_cmd.rd_start) r_sum <= '0;
            else if (i_cmd.acc_sum && r_vld) r_sum <= r_sum + SUM_W'(r_rd_data);
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                case (i_cmd.res_kind)
                    RES_FINISHED: r_wlen <= '0;
                    RES_LETTER: begin
                        r_first  <= r_second;
                        r_second <= r_pick[IDX_W-1:0];
                        r_wlen   <= r_wlen + 8'd1;
                    end
                    default: r_wlen <= r_wlen;
                endcase
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.op       = t_op'(r_item.opcode);
        o_sts.trained  = r_trained;
        o_sts.clr_last = (r_clr == ADDR_W'(DEPTH - 1));
        o_sts.mod_done = (r_bitcnt == BIT_W'(DVD_W));
        o_sts.rd_last  = rd_last;
        o_sts.step_end = (r_wlen == 8'd0) || (r_wlen >= r_max);
        o_sts.sum_zero = (r_sum == '0);
        o_sts.pick_end = !r_found || (r_pick == SEL_W'(ALPHABET_SIZE));
        o_sts.out_free = !r_out_valid;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    `TMLS_ASSERT_NEXT(a_walk_finds, i_clk, i_rst_n, i_cmd.walk && rd_last, r_found, "walk ended without a pick")
    `TMLS_ASSERT_NEXT(a_start_len, i_clk, i_rst_n, i_cmd.set_second, r_wlen == 8'd2, "start did not set length")
    `TMLS_ASSERT(a_emit_free, i_clk, i_rst_n, !(i_cmd.emit && r_out_valid), "result written over pending item")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for trigram_markov_letter_sampler: training, start and step items
// with random idling on both channels, checked against a scoreboard that tracks the counts.
// Depends on tmls_pkg and the block's RTL only.
module testbench;
    import tmls_pkg::*;

    localparam int LETTERS    = 26;
    localparam int SUCCESSORS = LETTERS + 1;
    localparam int END_MARK   = LETTERS;
    localparam int DEPTH      = LETTERS * LETTERS * SUCCESSORS;
    localparam int COUNT_TOP  = 65535;
    localparam int IDLE_LIMIT = 80000;
    localparam int SETTLE     = 200;

    class sampler_scoreboard;
        int unsigned counts[DEPTH];
        int unsigned older_char;
        int unsigned newer_char;
        int unsigned pair;
        int unsigned word_len;
        bit          trained;
        int unsigned max_len;
        t_out        pending[$];
        int          mismatches;
        int          results_seen;

        function new();
            foreach (counts[i]) counts[i] = 0;
            older_char = 63;
            newer_char = 63;
            pair = 0;
            word_len = 0;
            trained = 0;
            max_len = 16;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function int unsigned fold(logic [7:0] b);
            if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return b - CHAR_UPPER_A;
            if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) return b - CHAR_LOWER_A;
            return 63;
        endfunction

        function void bump(int unsigned c0, int unsigned c1, int unsigned nx);
            int unsigned idx;
            if (c0 >= LETTERS || c1 >= LETTERS) return;
            idx = (c0 * LETTERS + c1) * SUCCESSORS + nx;
            if (counts[idx] < COUNT_TOP) counts[idx]++;
        endfunction

        function int unsigned pair_sum(int unsigned p);
            int unsigned s;
            s = 0;
            for (int i = 0; i < SUCCESSORS; i++) s += counts[p * SUCCESSORS + i];
            return s;
        endfunction

        function void note_input(t_in x);
            t_out e;
            int unsigned c, c0, c1, tot, r, pick;
            e = '0;
            if (x.opcode == OP_TRAIN) begin
                c = fold(x.text_byte);
                bump(older_char, newer_char, (c == 63) ? END_MARK : c);
                older_char = newer_char;
                newer_char = c;
                if (x.end_of_word) begin
                    bump(older_char, newer_char, END_MARK);
                    older_char = 63;
                    newer_char = 63;
                end
                trained = 1;
                return;
            end
            if (x.opcode == OP_NONE) return;
            if (!trained) begin
                e.status = ST_UNTRAINED;
            end else if (x.opcode == OP_START) begin
                c0 = x.random_a % LETTERS;
                c1 = x.random_b % LETTERS;
                pair = c0 * LETTERS + c1;
                word_len = 2;
                e.status = ST_LETTER;
                e.letter = 8'(CHAR_UPPER_A + c0);
                e.second_letter = 8'(CHAR_LOWER_A + c1);
                e.pair_has_successor = (pair_sum(pair) != 0);
            end else begin
                e.status = ST_FINISHED;
                tot = pair_sum(pair);
                if (word_len == 0 || word_len >= max_len || tot == 0) begin
                    word_len = 0;
                end else begin
                    r = x.random_a % tot;
                    pick = END_MARK;
                    for (int i = 0; i < SUCCESSORS; i++) begin
                        if (r < counts[pair * SUCCESSORS + i]) begin
                            pick = i;
                            break;
                        end
                        r -= counts[pair * SUCCESSORS + i];
                    end
                    if (pick >= END_MARK) begin
                        word_len = 0;
                    end else begin
                        pair = (pair % LETTERS) * LETTERS + pick;
                        word_len++;
                        e.status = ST_LETTER;
                        e.letter = 8'(CHAR_LOWER_A + pick);
                    end
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(t_out y);
            t_out e;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", y);
                return;
            end
            e = pending.pop_front();
            if (y.status !== e.status || y.letter !== e.letter ||
                y.second_letter !== e.second_letter ||
                y.pair_has_successor !== e.pair_has_successor) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: status %0d/%0d letter %h/%h second %h/%h succ %b/%b",
                             e.status, y.status, e.letter, y.letter,
                             e.second_letter, y.second_letter,
                             e.pair_has_successor, y.pair_has_successor);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    logic i_cfg_valid, o_cfg_ready;
    logic [7:0] i_cfg_data;
    t_in  i_item;
    t_out o_item;

    sampler_scoreboard sb;
    bit  no_idle;
    int  items_sent;
    int  idle_cycles = 0;
    int  words_started;
    int  trained_pairs[$];

    trigram_markov_letter_sampler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    // Results are checked and the watchdog advanced on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_item);
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : result_sink
        int gap;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    task automatic send_item(t_in x);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= x;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(x);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_max_len(logic [7:0] v);
        i_valid     <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.max_len = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for every expected result, then let any training item in flight finish.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function t_in make_item(t_op op, logic [7:0] b, logic eow, int unsigned ra,
                            int unsigned rb);
        t_in x;
        x.opcode = op;
        x.text_byte = b;
        x.end_of_word = eow;
        x.random_a = ra[30:0];
        x.random_b = rb[30:0];
        return x;
    endfunction

    function int unsigned rand31();
        return $urandom() & 32'h7fff_ffff;
    endfunction

    task automatic train_text(string s, bit eow_last);
        for (int i = 0; i < s.len(); i++)
            send_item(make_item(OP_TRAIN, s[i], eow_last && (i == s.len() - 1),
                                rand31(), rand31()));
    endtask

    // Random word: mostly a few common letters, random case, ended by a flag or a non-letter.
    task automatic train_random_word();
        int n, idx, prev;
        logic [7:0] b;
        n = $urandom_range(1, 8);
        prev = -1;
        for (int i = 0; i < n; i++) begin
            idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 25) : $urandom_range(0, 5);
            b = 8'(($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + idx);
            if (prev >= 0) trained_pairs.push_back(prev * LETTERS + idx);
            prev = idx;
            send_item(make_item(OP_TRAIN, b, (i == n - 1) && $urandom_range(0, 1),
                                rand31(), rand31()));
        end
        if (sb.newer_char != 63) begin
            do b = 8'($urandom_range(0, 255)); while (sb.fold(b) != 63);
            send_item(make_item(OP_TRAIN, b, 1'($urandom_range(0, 1)), rand31(), rand31()));
        end
    endtask

    task automatic sample_word();
        int unsigned p, ra, rb;
        int steps;
        if (trained_pairs.size() != 0 && $urandom_range(0, 9) < 8) begin
            p = trained_pairs[$urandom_range(0, trained_pairs.size() - 1)];
            ra = (p / LETTERS) + LETTERS * $urandom_range(0, 82595000);
            rb = (p % LETTERS) + LETTERS * $urandom_range(0, 82595000);
        end else begin
            ra = rand31();
            rb = rand31();
        end
        send_item(make_item(OP_START, 8'($urandom()), 1'($urandom()), ra, rb));
        words_started++;
        steps = 0;
        while (sb.word_len != 0 && steps < 40) begin
            send_item(make_item(OP_STEP, 8'($urandom()), 1'($urandom()), rand31(), rand31()));
            steps++;
        end
        // Sometimes step once more past the end to hit the no-active-word case.
        if ($urandom_range(0, 3) == 0)
            send_item(make_item(OP_STEP, 8'($urandom()), 1'($urandom()), rand31(), rand31()));
    endtask

    task automatic random_phase(int target);
        int r;
        while (items_sent < target) begin
            no_idle = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 9);
            if (r < 4) train_random_word();
            else if (r < 9) sample_word();
            else send_item(make_item(t_op'($urandom_range(0, 3)), 8'($urandom()),
                                     1'($urandom()), rand31(), rand31()));
        end
    endtask

    initial begin
        sb = new();
        no_idle = 1'b0;
        items_sent = 0;
        words_started = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_item = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Untrained, unused opcode, then training with mixed case and punctuation.
        send_item(make_item(OP_START, 8'hff, 1'b1, 31'h7fffffff, 31'h7fffffff));
        send_item(make_item(OP_STEP, 8'h00, 1'b0, 0, 0));
        send_item(make_item(OP_NONE, 8'h41, 1'b1, rand31(), rand31()));
        train_text("The", 1'b1);
        train_text("cAt sat!", 1'b0);
        train_text("thE", 1'b1);
        send_item(make_item(OP_TRAIN, 8'hff, 1'b1, 0, 31'h7fffffff));
        send_item(make_item(OP_TRAIN, 8'h00, 1'b0, 31'h7fffffff, 0));
        // Empty pair "zz", then steps until done, then a step with no word.
        send_item(make_item(OP_START, 0, 0, 25, 25 + 26 * 1000));
        send_item(make_item(OP_STEP, 0, 0, rand31(), 0));
        send_item(make_item(OP_STEP, 0, 0, rand31(), 0));
        send_item(make_item(OP_START, 0, 0, 19, 7));
        for (int i = 0; i < 4; i++)
            send_item(make_item(OP_STEP, 0, 0, rand31(), rand31()));
        drain();

        // Build up a large "aaa" count with back-to-back items.
        no_idle = 1'b1;
        for (int i = 0; i < 200; i++)
            send_item(make_item(OP_TRAIN, CHAR_LOWER_A, 1'b0, 0, 0));
        send_item(make_item(OP_TRAIN, CHAR_LOWER_A, 1'b1, 0, 0));
        trained_pairs.push_back(0);
        no_idle = 1'b0;
        send_item(make_item(OP_START, 0, 0, 0, 0));
        send_item(make_item(OP_STEP, 0, 0, 31'h7fffffff, 0));
        drain();

        write_max_len(8'd2);
        random_phase(items_sent + 200);
        drain();
        write_max_len(8'd255);
        random_phase(items_sent + 400);
        drain();
        write_max_len(8'd0);
        random_phase(items_sent + 150);
        drain();
        write_max_len(8'($urandom_range(3, 12)));
        random_phase(items_sent + 400);
        drain();
        write_max_len(8'd16);
        random_phase(items_sent + 300);
        drain();

        $display("covered %0d items, %0d results, %0d generated words, five length limits",
                 items_sent, sb.results_seen, words_started);
        $display("including a long back-to-back 'aaa' training run; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
